>>> src/mpdm_pkg.sv
// Shared types, constants and register map of the pin debounce monitor.
package mpdm_pkg;

  // Width of the pin and mask fields
  localparam int unsigned FIELD_W = 18;

  // Default for the lane count
  localparam int unsigned CHANNELS_DEF = 18;

  // Register widths
  localparam int unsigned JUDGE_W = 16;
  localparam int unsigned WAIT_W  = 8;
  localparam int unsigned CFG_W   = FIELD_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JUDGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_MASK   = 2'd2;

  // Register reset values
  localparam logic [JUDGE_W-1:0] JUDGE_RESET = 16'd3;
  localparam logic [WAIT_W-1:0]  WAIT_RESET  = 8'd0;
  localparam logic [FIELD_W-1:0] SLOW_RESET  = 18'h00100;

  // Common settings seen by every lane
  typedef struct packed {
    logic [JUDGE_W-1:0] judge_count;
    logic [WAIT_W-1:0]  wait_time;
  } lane_cfg_t;

  // What one lane reports after an update
  typedef struct packed {
    logic known;
    logic level;
  } lane_res_t;

endpackage

>>> src/mpdm_lane.sv
// One channel of the debounce monitor: start wait, sampling and confirmation.
module mpdm_lane
  import mpdm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      pin_i,
  input  logic      enable_i,
  input  logic      slow_i,
  input  lane_cfg_t cfg_i,
  output lane_res_t res_o
);

  logic               last_valid_q, last_valid_d;
  logic               last_level_q, last_level_d;
  logic               poll_q, poll_d;
  logic               samp_q, samp_d;
  logic [JUDGE_W-1:0] same_q, same_d;
  logic               known_q, known_d;
  logic               level_q, level_d;
  logic [WAIT_W-1:0]  wait_q, wait_d;

  logic               match;
  logic [JUDGE_W-1:0] same_smp;

  // Work out the count after a sample
  always_comb begin
    match = last_valid_q && (last_level_q == pin_i);
    if (match) begin
      if (same_q < cfg_i.judge_count) begin
        same_smp = same_q + JUDGE_W'(1);
      end else begin
        same_smp = same_q;
      end
    end else begin
      same_smp = JUDGE_W'(1);
    end
  end

  // Next state of the channel for this word
  always_comb begin
    last_valid_d = last_valid_q;
    last_level_d = last_level_q;
    poll_d       = poll_q;
    samp_d       = samp_q;
    same_d       = same_q;
    known_d      = known_q;
    level_d      = level_q;
    wait_d       = wait_q;
    if (!enable_i) begin
      last_valid_d = 1'b0;
      last_level_d = 1'b0;
      poll_d       = 1'b0;
      samp_d       = 1'b0;
      same_d       = JUDGE_W'(1);
      known_d      = 1'b0;
      level_d      = 1'b0;
      wait_d       = cfg_i.wait_time;
    end else begin
      if (wait_q == '0) begin
        poll_d = 1'b1;
      end else begin
        wait_d = wait_q - WAIT_W'(1);
      end
      if (poll_d) begin
        if (!samp_q) begin
          same_d       = same_smp;
          if (same_smp >= cfg_i.judge_count) begin
            known_d = 1'b1;
            level_d = pin_i;
          end
          last_valid_d = 1'b1;
          last_level_d = pin_i;
          samp_d       = slow_i;
        end else begin
          samp_d = 1'b0;
        end
      end else begin
        same_d = JUDGE_W'(1);
      end
    end
  end

  // Advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
      last_level_q <= 1'b0;
      poll_q       <= 1'b0;
      samp_q       <= 1'b0;
      same_q       <= JUDGE_W'(1);
      known_q      <= 1'b0;
      level_q      <= 1'b0;
      wait_q       <= WAIT_RESET;
    end else if (step_i) begin
      last_valid_q <= last_valid_d;
      last_level_q <= last_level_d;
      poll_q       <= poll_d;
      samp_q       <= samp_d;
      same_q       <= same_d;
      known_q      <= known_d;
      level_q      <= level_d;
      wait_q       <= wait_d;
    end
  end

  // Report the state after this word's update
  assign res_o.known = known_d;
  assign res_o.level = level_d & known_d;

endmodule

>>> src/mpdm_merge.sv
// Gathers the lane results into masks and holds them in a two-entry output buffer.
module mpdm_merge
  import mpdm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lane_res_t          res_i [CHANNELS],
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FIELD_W-1:0] known_mask_o,
  output logic [FIELD_W-1:0] level_mask_o
);

  logic [FIELD_W-1:0] known_new, level_new;
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_known_q, out_level_q;
  logic               skid_valid_q;
  logic [FIELD_W-1:0] skid_known_q, skid_level_q;
  logic               pop;

  // Pack the lane results into masks
  always_comb begin
    known_new = '0;
    level_new = '0;
    for (int unsigned i = 0; i < CHANNELS; i++) begin
      if (i < FIELD_W) begin
        known_new[i] = res_i[i].known;
        level_new[i] = res_i[i].level;
      end
    end
  end

  assign pop = out_valid_q && !out_stall_i;

  // Hold control of the output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  // Load the output words
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_known_q <= skid_known_q;
      out_level_q <= skid_level_q;
    end else if (push_i && (pop || !out_valid_q)) begin
      out_known_q <= known_new;
      out_level_q <= level_new;
    end
    if (push_i && out_valid_q && !pop) begin
      skid_known_q <= known_new;
      skid_level_q <= level_new;
    end
  end

  assign full_o       = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign known_mask_o = out_known_q;
  assign level_mask_o = out_level_q;

endmodule

>>> src/multi_pin_debounce_monitor_core.sv
// Top level of the pin debounce monitor: registers, channel lanes and output merge.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  in      | in_valid_i/in_stall_o | pin_levels_i, monitor_enables_i
//  out     | out_valid_o/out_stall_i | known_mask_o, level_mask_o
//  cfg     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One word is taken per cycle while the input is not stalled; every lane updates
// in the cycle of acceptance and the masks are registered in the output buffer.
// A two-entry output buffer lets input flow on while a result waits; the input
// stalls only when both entries are full.
// Reset loads register defaults, clears every channel and empties the buffer.
module multi_pin_debounce_monitor_core
  import mpdm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FIELD_W-1:0]   pin_levels_i,
  input  logic [FIELD_W-1:0]   monitor_enables_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FIELD_W-1:0]   known_mask_o,
  output logic [FIELD_W-1:0]   level_mask_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [JUDGE_W-1:0] judge_q;
  logic [WAIT_W-1:0]  wait_q;
  logic [FIELD_W-1:0] slow_q;
  lane_cfg_t          lane_cfg;
  lane_res_t          lane_res [CHANNELS];
  logic               full;
  logic               step;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      judge_q <= JUDGE_RESET;
      wait_q  <= WAIT_RESET;
      slow_q  <= SLOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_JUDGE_COUNT: judge_q <= cfg_data_i[JUDGE_W-1:0];
        REG_WAIT_TIME:   wait_q  <= cfg_data_i[WAIT_W-1:0];
        REG_SLOW_MASK:   slow_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lane_cfg.judge_count = judge_q;
  assign lane_cfg.wait_time   = wait_q;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  // One lane per channel; channels past the field width stay cleared
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic pin, en, slow;
    if (i < FIELD_W) begin : g_in
      assign pin  = pin_levels_i[i];
      assign en   = monitor_enables_i[i];
      assign slow = slow_q[i];
    end else begin : g_off
      assign pin  = 1'b0;
      assign en   = 1'b0;
      assign slow = 1'b0;
    end
    mpdm_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .pin_i    (pin),
      .enable_i (en),
      .slow_i   (slow),
      .cfg_i    (lane_cfg),
      .res_o    (lane_res[i])
    );
  end

  mpdm_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (step),
    .res_i        (lane_res),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .known_mask_o (known_mask_o),
    .level_mask_o (level_mask_o)
  );

endmodule

>>> src/mpdm_checker.sv
// Port-level checks of the pin debounce monitor and their binding to the top level.
module mpdm_checker
  import mpdm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [FIELD_W-1:0] known_mask_o,
  input logic [FIELD_W-1:0] level_mask_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(known_mask_o)
      && $stable(level_mask_o))
    else $error("stalled result word changed");

  // Drop level bits on channels without a confirmed level
  a_level_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_mask_o & ~known_mask_o) == '0)
    else $error("level set on an unknown channel");

  // Raise a result only after an accepted word
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted word");

  // Stall input only while a result waits
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind multi_pin_debounce_monitor_core mpdm_checker u_mpdm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .known_mask_o (known_mask_o),
  .level_mask_o (level_mask_o)
);
